@@ hw/rtl/tss_pkg.sv @@
// Shared types and constants of the task slot scheduler.
// Used by tss_ctrl, tss_dp and task_slot_scheduler; depends on nothing.
package tss_pkg;

   // Defaults of the top level parameters
   localparam int MAX_SLOTS_DEF  = 16;
   localparam int TIME_BITS_DEF  = 48;
   localparam int STAMP_BITS_DEF = 48;

   // Fixed widths of the transaction fields
   localparam int CMD_W        = 3;
   localparam int SLOT_FIELD_W = 5;
   localparam int NOW_W        = 48;
   localparam int DUR_W        = 40;
   localparam int CFG_W        = 5;
   localparam int OUTCOME_W    = 2;
   localparam int CHOSEN_W     = 4;
   localparam int PROM_W       = 5;

   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_RESERVE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_START    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SUSPEND  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TICK     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd4;
   localparam logic [CMD_W-1:0] CMD_YIELD    = 3'd5;
   localparam logic [CMD_W-1:0] CMD_FINISH   = 3'd6;

   // Outcome codes
   localparam logic [OUTCOME_W-1:0] OUT_DONE      = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUT_IGNORED   = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUT_CANCELLED = 2'd2;
   localparam logic [OUTCOME_W-1:0] OUT_RANGE     = 2'd3;

   typedef enum logic [2:0] {
      ST_FREE,
      ST_RESERVED,
      ST_READY,
      ST_TIMED,
      ST_RUNNING
   } slot_status_type;

   // Datapath operation requested by the controller
   typedef enum logic [2:0] {
      OP_IDLE,
      OP_LOAD,
      OP_EXEC,
      OP_SELECT,
      OP_COMMIT,
      OP_SUMMARY,
      OP_PUBLISH
   } dp_op_type;

   // Status returned by the datapath
   typedef struct packed {
      logic is_tick;
      logic is_dispatch;
      logic scan_done;
      logic found;
      logic out_free;
   } dp_status_type;

endpackage

@@ hw/rtl/tss_ctrl.sv @@
// Controller state machine of the task slot scheduler.
// Depends on tss_pkg; drives datapath operations from datapath status.
module tss_ctrl import tss_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type dp_status,
   output dp_op_type     dp_op
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SELECT,
      S_COMMIT,
      S_SUMMARY,
      S_PUBLISH
   } state_type;

   state_type state_ff, state_in;

   // Take a new transaction only when idle
   assign req_stall = (state_ff != S_IDLE);

   // Next state and datapath operation
   always_comb begin
      state_in = state_ff;
      dp_op    = OP_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_op    = OP_LOAD;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            dp_op = OP_EXEC;
            if (dp_status.is_tick || dp_status.is_dispatch) begin
               state_in = S_SELECT;
            end else begin
               state_in = S_SUMMARY;
            end
         end
         S_SELECT: begin
            dp_op = OP_SELECT;
            if (dp_status.scan_done) begin
               state_in = dp_status.found ? S_COMMIT : S_SUMMARY;
            end
         end
         S_COMMIT: begin
            dp_op    = OP_COMMIT;
            state_in = dp_status.is_tick ? S_SELECT : S_SUMMARY;
         end
         S_SUMMARY: begin
            dp_op = OP_SUMMARY;
            if (dp_status.scan_done) begin
               state_in = S_PUBLISH;
            end
         end
         S_PUBLISH: begin
            if (dp_status.out_free) begin
               dp_op    = OP_PUBLISH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/tss_dp.sv @@
// Datapath of the task slot scheduler: slot table, stamps, scan unit and
// result register. Depends on tss_pkg; sequenced by tss_ctrl.
module tss_dp import tss_pkg::*; #(
   parameter int MAX_SLOTS  = MAX_SLOTS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF,
   parameter int STAMP_BITS = STAMP_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [CMD_W-1:0]        req_cmd,
   input  logic [SLOT_FIELD_W-1:0] req_slot,
   input  logic                    req_admit,
   input  logic [NOW_W-1:0]        req_now,
   input  logic [DUR_W-1:0]        req_duration,
   input  logic                    csr_wr_en,
   input  logic [CFG_W-1:0]        csr_wr_data,
   input  dp_op_type               dp_op,
   output dp_status_type           dp_status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [OUTCOME_W-1:0]    rsp_outcome,
   output logic [CHOSEN_W-1:0]     rsp_chosen_slot,
   output logic                    rsp_chosen_valid,
   output logic [PROM_W-1:0]       rsp_promoted_count,
   output logic                    rsp_positive_wait,
   output logic                    rsp_any_ready,
   output logic                    rsp_any_timed,
   output logic [NOW_W-1:0]        rsp_earliest_deadline
);

   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W  = (CNT_W > SLOT_FIELD_W) ? CNT_W : SLOT_FIELD_W;
   localparam int SUM_W  = ((TIME_BITS > DUR_W) ? TIME_BITS : DUR_W) + 1;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   // Configuration and captured transaction
   logic [CFG_W-1:0]        cfg_ff;
   logic [CMD_W-1:0]        cmd_ff;
   logic [SLOT_FIELD_W-1:0] slot_ff;
   logic                    admit_ff;
   logic [TIME_BITS-1:0]    now_ff;
   logic [DUR_W-1:0]        dur_ff;

   // Slot table
   slot_status_type         status_ff [MAX_SLOTS];
   logic [TIME_BITS-1:0]    deadline_mem [MAX_SLOTS];
   logic [STAMP_BITS-1:0]   rstamp_mem [MAX_SLOTS];
   logic [STAMP_BITS-1:0]   tstamp_mem [MAX_SLOTS];
   logic [STAMP_BITS-1:0]   next_rs_ff;
   logic [STAMP_BITS-1:0]   next_ts_ff;

   // Scan unit
   logic [CNT_W-1:0]        idx_ff;
   logic                    rd_vld_ff;
   logic [SLOT_W-1:0]       rd_idx_ff;
   slot_status_type         rd_st_ff;
   logic [TIME_BITS-1:0]    rd_dl_ff;
   logic [STAMP_BITS-1:0]   rd_rs_ff;
   logic [STAMP_BITS-1:0]   rd_ts_ff;
   logic                    found_ff;
   logic [SLOT_W-1:0]       best_idx_ff;
   logic [TIME_BITS-1:0]    best_dl_ff;
   logic [STAMP_BITS-1:0]   best_st_ff;

   // Result under construction
   logic [OUTCOME_W-1:0]    outcome_ff;
   logic [SLOT_W-1:0]       chosen_ff;
   logic                    chosen_vld_ff;
   logic [CNT_W-1:0]        prom_ff;
   logic                    pos_ff;
   logic                    any_ready_ff;
   logic                    any_timed_ff;
   logic [TIME_BITS-1:0]    earliest_ff;

   // Result register
   logic                    rsp_valid_ff;
   logic [OUTCOME_W-1:0]    rsp_outcome_ff;
   logic [CHOSEN_W-1:0]     rsp_chosen_ff;
   logic                    rsp_chosen_vld_ff;
   logic [PROM_W-1:0]       rsp_prom_ff;
   logic                    rsp_pos_ff;
   logic                    rsp_any_ready_ff;
   logic                    rsp_any_timed_ff;
   logic [NOW_W-1:0]        rsp_earliest_ff;

   logic [CMP_W-1:0]        n_cmp;
   logic [CNT_W-1:0]        n_use;
   logic [SLOT_W-1:0]       slot_idx;
   logic                    slot_cmd;
   logic                    slot_bad;
   logic                    is_tick;
   logic                    is_dispatch;
   logic                    scan_more;
   logic                    scan_done;
   logic [SLOT_W-1:0]       rd_addr;
   logic                    rd_en;
   logic [SUM_W-1:0]        wake_sum;
   logic [TIME_BITS-1:0]    wake_time;
   logic                    due;
   logic                    sel_hit;
   logic [STAMP_BITS-1:0]   cand_st;
   logic                    st_we;
   logic [SLOT_W-1:0]       wr_addr;
   slot_status_type         st_wval;
   logic                    rs_we;
   logic                    tm_we;
   logic [OUTCOME_W-1:0]    ex_outcome;
   logic                    ex_pos;
   logic                    out_free;

   // Count in use and range check
   assign n_cmp = (CMP_W'(cfg_ff) > CMP_W'(MAX_SLOTS)) ? CMP_W'(MAX_SLOTS) : CMP_W'(cfg_ff);
   assign n_use = CNT_W'(n_cmp);
   assign slot_idx = SLOT_W'(slot_ff);
   assign slot_cmd = (cmd_ff == CMD_RESERVE) || (cmd_ff == CMD_START) ||
                     (cmd_ff == CMD_SUSPEND) || (cmd_ff == CMD_YIELD) ||
                     (cmd_ff == CMD_FINISH);
   assign slot_bad = slot_cmd && (CMP_W'(slot_ff) >= n_cmp);
   assign is_tick     = (cmd_ff == CMD_TICK);
   assign is_dispatch = (cmd_ff == CMD_DISPATCH);

   // Scan progress
   assign scan_more = (idx_ff < n_use);
   assign scan_done = !scan_more && !rd_vld_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign dp_status.is_tick     = is_tick;
   assign dp_status.is_dispatch = is_dispatch;
   assign dp_status.scan_done   = scan_done;
   assign dp_status.found       = found_ff;
   assign dp_status.out_free    = out_free;

   // Single table read port: addressed slot on load, scan index otherwise
   assign rd_addr = (dp_op == OP_LOAD) ? SLOT_W'(req_slot) : idx_ff[SLOT_W-1:0];
   assign rd_en   = (dp_op == OP_LOAD) ||
                    (((dp_op == OP_SELECT) || (dp_op == OP_SUMMARY)) && scan_more);

   // Saturating wake time for suspend
   assign wake_sum  = SUM_W'(now_ff) + SUM_W'(dur_ff);
   assign wake_time = (wake_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : wake_sum[TIME_BITS-1:0];

   // Candidate compare for tick (earliest due) and dispatch (oldest ready)
   assign due = (rd_st_ff == ST_TIMED) && (rd_dl_ff <= now_ff);
   assign cand_st = is_tick ? rd_ts_ff : rd_rs_ff;
   always_comb begin
      if (is_tick) begin
         sel_hit = due && (!found_ff || (rd_dl_ff < best_dl_ff) ||
                   ((rd_dl_ff == best_dl_ff) && (rd_ts_ff < best_st_ff)));
      end else begin
         sel_hit = (rd_st_ff == ST_READY) && (!found_ff || (rd_rs_ff < best_st_ff));
      end
   end

   // Table write decode for execute and commit
   always_comb begin
      st_we      = 1'b0;
      st_wval    = ST_FREE;
      rs_we      = 1'b0;
      tm_we      = 1'b0;
      ex_outcome = OUT_IGNORED;
      ex_pos     = 1'b0;
      wr_addr    = slot_idx;
      if (dp_op == OP_COMMIT) begin
         wr_addr = best_idx_ff;
         st_we   = 1'b1;
         if (is_tick) begin
            st_wval = ST_READY;
            rs_we   = 1'b1;
         end else begin
            st_wval = ST_RUNNING;
         end
      end else if (dp_op == OP_EXEC) begin
         if (slot_bad) begin
            ex_outcome = OUT_RANGE;
         end else begin
            case (cmd_ff)
               CMD_RESERVE: begin
                  if (rd_st_ff == ST_FREE) begin
                     st_we      = 1'b1;
                     st_wval    = ST_RESERVED;
                     ex_outcome = OUT_DONE;
                  end
               end
               CMD_START: begin
                  if (rd_st_ff == ST_RESERVED) begin
                     st_we = 1'b1;
                     if (admit_ff) begin
                        st_wval    = ST_READY;
                        rs_we      = 1'b1;
                        ex_outcome = OUT_DONE;
                     end else begin
                        st_wval    = ST_FREE;
                        ex_outcome = OUT_CANCELLED;
                     end
                  end
               end
               CMD_SUSPEND: begin
                  if ((rd_st_ff == ST_RUNNING) && (dur_ff != '0)) begin
                     st_we      = 1'b1;
                     st_wval    = ST_TIMED;
                     tm_we      = 1'b1;
                     ex_pos     = (wake_time > now_ff);
                     ex_outcome = OUT_DONE;
                  end
               end
               CMD_YIELD: begin
                  if (rd_st_ff == ST_RUNNING) begin
                     st_we      = 1'b1;
                     st_wval    = ST_READY;
                     rs_we      = 1'b1;
                     ex_outcome = OUT_DONE;
                  end
               end
               CMD_FINISH: begin
                  if (rd_st_ff == ST_RUNNING) begin
                     st_we      = 1'b1;
                     st_wval    = ST_FREE;
                     ex_outcome = OUT_DONE;
                  end
               end
               default: begin
                  ex_outcome = OUT_IGNORED;
               end
            endcase
         end
      end
   end

   // Hold slot status, stamp counters and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SLOTS; i++) begin
            status_ff[i] <= ST_FREE;
         end
         next_rs_ff <= '0;
         next_ts_ff <= '0;
         cfg_ff     <= CFG_RESET;
      end else begin
         if (st_we) begin
            status_ff[wr_addr] <= st_wval;
         end
         if (rs_we) begin
            next_rs_ff <= next_rs_ff + 1'b1;
         end
         if (tm_we) begin
            next_ts_ff <= next_ts_ff + 1'b1;
         end
         if (csr_wr_en) begin
            cfg_ff <= csr_wr_data;
         end
      end
   end

   // Write deadline and stamp stores
   always_ff @(posedge clock) begin
      if (rs_we) begin
         rstamp_mem[wr_addr] <= next_rs_ff;
      end
      if (tm_we) begin
         deadline_mem[wr_addr] <= wake_time;
         tstamp_mem[wr_addr]   <= next_ts_ff;
      end
   end

   // Registered table read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_idx_ff <= rd_addr;
         rd_st_ff  <= status_ff[rd_addr];
         rd_dl_ff  <= deadline_mem[rd_addr];
         rd_rs_ff  <= rstamp_mem[rd_addr];
         rd_ts_ff  <= tstamp_mem[rd_addr];
      end
   end

   // Capture transaction
   always_ff @(posedge clock) begin
      if (dp_op == OP_LOAD) begin
         cmd_ff   <= req_cmd;
         slot_ff  <= req_slot;
         admit_ff <= req_admit;
         now_ff   <= TIME_BITS'(req_now);
         dur_ff   <= req_duration;
      end
   end

   // Scan index and pipeline valid; rewind the index once the last read drained
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         case (dp_op)
            OP_SELECT, OP_SUMMARY: begin
               rd_vld_ff <= scan_more;
               if (scan_more) begin
                  idx_ff <= idx_ff + 1'b1;
               end else if (!rd_vld_ff) begin
                  idx_ff <= '0;
               end
            end
            OP_EXEC, OP_COMMIT: begin
               rd_vld_ff <= 1'b0;
               idx_ff    <= '0;
            end
            default: begin
               rd_vld_ff <= 1'b0;
            end
         endcase
      end
   end

   // Build the result
   always_ff @(posedge clock) begin
      case (dp_op)
         OP_EXEC: begin
            outcome_ff    <= ex_outcome;
            pos_ff        <= ex_pos;
            chosen_ff     <= '0;
            chosen_vld_ff <= 1'b0;
            prom_ff       <= '0;
            found_ff      <= 1'b0;
            any_ready_ff  <= 1'b0;
            any_timed_ff  <= 1'b0;
            earliest_ff   <= TIME_MAX;
         end
         OP_SELECT: begin
            if (rd_vld_ff && sel_hit) begin
               found_ff    <= 1'b1;
               best_idx_ff <= rd_idx_ff;
               best_dl_ff  <= rd_dl_ff;
               best_st_ff  <= cand_st;
            end
         end
         OP_COMMIT: begin
            found_ff   <= 1'b0;
            outcome_ff <= OUT_DONE;
            if (is_tick) begin
               prom_ff <= prom_ff + 1'b1;
            end else begin
               chosen_ff     <= best_idx_ff;
               chosen_vld_ff <= 1'b1;
            end
         end
         OP_SUMMARY: begin
            if (rd_vld_ff) begin
               if (rd_st_ff == ST_READY) begin
                  any_ready_ff <= 1'b1;
               end
               if (rd_st_ff == ST_TIMED) begin
                  any_timed_ff <= 1'b1;
                  if (rd_dl_ff < earliest_ff) begin
                     earliest_ff <= rd_dl_ff;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Result register handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_op == OP_PUBLISH) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Load result payload
   always_ff @(posedge clock) begin
      if (dp_op == OP_PUBLISH) begin
         rsp_outcome_ff    <= outcome_ff;
         rsp_chosen_ff     <= CHOSEN_W'(chosen_ff);
         rsp_chosen_vld_ff <= chosen_vld_ff;
         rsp_prom_ff       <= PROM_W'(prom_ff);
         rsp_pos_ff        <= pos_ff;
         rsp_any_ready_ff  <= any_ready_ff;
         rsp_any_timed_ff  <= any_timed_ff;
         rsp_earliest_ff   <= NOW_W'(earliest_ff);
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_outcome           = rsp_outcome_ff;
   assign rsp_chosen_slot       = rsp_chosen_ff;
   assign rsp_chosen_valid      = rsp_chosen_vld_ff;
   assign rsp_promoted_count    = rsp_prom_ff;
   assign rsp_positive_wait     = rsp_pos_ff;
   assign rsp_any_ready         = rsp_any_ready_ff;
   assign rsp_any_timed         = rsp_any_timed_ff;
   assign rsp_earliest_deadline = rsp_earliest_ff;

endmodule

@@ hw/rtl/task_slot_scheduler.sv @@
// Task slot scheduler top level: controller and datapath.
// Depends on tss_pkg, tss_ctrl and tss_dp.
//
// Usage: one command transaction enters on the req_ channel (valid/stall)
// and produces exactly one result transaction on the rsp_ channel.
// csr_wr_en/csr_wr_data set the number of slots in use; write only while
// the block is idle. Reset (synchronous) frees every slot, clears both
// stamp counters and sets the slots in use to 16.
// Sequence after accept: every scan reads one slot per cycle through the
// single table read port. Reserve, start, suspend, yield, finish and
// unknown commands run execute, one summary scan and publish. Dispatch
// adds a selection scan before the summary, with a commit when a slot is
// dispatched. Tick runs one selection scan per promoted slot, each
// followed by a commit, plus a final empty one before the summary.
// One transaction is processed at a time; req_stall is high from accept
// until the result is loaded into the output register. A finished result
// waits in that register while rsp_stall is high, and the next command is
// accepted meanwhile; its own result waits until the register is free.
module task_slot_scheduler import tss_pkg::*; #(
   parameter int MAX_SLOTS  = MAX_SLOTS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF,
   parameter int STAMP_BITS = STAMP_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [CMD_W-1:0]        req_cmd,
   input  logic [SLOT_FIELD_W-1:0] req_slot,
   input  logic                    req_admit,
   input  logic [NOW_W-1:0]        req_now,
   input  logic [DUR_W-1:0]        req_duration,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [OUTCOME_W-1:0]    rsp_outcome,
   output logic [CHOSEN_W-1:0]     rsp_chosen_slot,
   output logic                    rsp_chosen_valid,
   output logic [PROM_W-1:0]       rsp_promoted_count,
   output logic                    rsp_positive_wait,
   output logic                    rsp_any_ready,
   output logic                    rsp_any_timed,
   output logic [NOW_W-1:0]        rsp_earliest_deadline,
   input  logic                    csr_wr_en,
   input  logic [CFG_W-1:0]        csr_wr_data
);

   dp_op_type     dp_op;
   dp_status_type dp_status;

   // Sequencer
   tss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_op     (dp_op)
   );

   // Slot table and scan datapath
   tss_dp #(
      .MAX_SLOTS  (MAX_SLOTS),
      .TIME_BITS  (TIME_BITS),
      .STAMP_BITS (STAMP_BITS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .req_cmd               (req_cmd),
      .req_slot              (req_slot),
      .req_admit             (req_admit),
      .req_now               (req_now),
      .req_duration          (req_duration),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .dp_op                 (dp_op),
      .dp_status             (dp_status),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_outcome           (rsp_outcome),
      .rsp_chosen_slot       (rsp_chosen_slot),
      .rsp_chosen_valid      (rsp_chosen_valid),
      .rsp_promoted_count    (rsp_promoted_count),
      .rsp_positive_wait     (rsp_positive_wait),
      .rsp_any_ready         (rsp_any_ready),
      .rsp_any_timed         (rsp_any_timed),
      .rsp_earliest_deadline (rsp_earliest_deadline)
   );

endmodule
